FILE: sv/u2u8_pkg.sv
// Shared types, constants and the UTF-8 encode function for the UTF-16 to UTF-8 transcoder.
package u2u8_pkg;

   localparam int UNIT_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int CP_W      = 21;
   localparam int MAX_BYTES = 6;
   localparam int CNT_W     = 3;
   localparam int IDX_W     = 3;
   localparam int SURR_W    = 10;

   // top six bits of a surrogate code unit
   localparam logic [5:0] HIGH_TAG = 6'h36;
   localparam logic [5:0] LOW_TAG  = 6'h37;

   localparam logic [CP_W-1:0] SUPP_BASE   = 21'h10000;
   localparam logic [CP_W-1:0] REPL_CP     = 21'h0FFFD;
   localparam logic [CP_W-1:0] LIMIT_1BYTE = 21'h00080;
   localparam logic [CP_W-1:0] LIMIT_2BYTE = 21'h00800;
   localparam logic [CP_W-1:0] LIMIT_3BYTE = 21'h10000;

   localparam logic [BYTE_W-1:0] LEAD2_TAG = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_TAG = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_TAG = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

   typedef struct packed {
      logic [3:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]       count;
   } point_type;

   // bytes[0] goes out first
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]                 count;
   } burst_type;

   function automatic point_type encode_point(logic [CP_W-1:0] cp);
      point_type p;
      p = '0;
      if (cp < LIMIT_1BYTE) begin
         p.bytes[0] = cp[7:0];
         p.count    = 3'd1;
      end else if (cp < LIMIT_2BYTE) begin
         p.bytes[0] = LEAD2_TAG | {3'b000, cp[10:6]};
         p.bytes[1] = CONT_TAG  | {2'b00, cp[5:0]};
         p.count    = 3'd2;
      end else if (cp < LIMIT_3BYTE) begin
         p.bytes[0] = LEAD3_TAG | {4'b0000, cp[15:12]};
         p.bytes[1] = CONT_TAG  | {2'b00, cp[11:6]};
         p.bytes[2] = CONT_TAG  | {2'b00, cp[5:0]};
         p.count    = 3'd3;
      end else begin
         p.bytes[0] = LEAD4_TAG | {5'b00000, cp[20:18]};
         p.bytes[1] = CONT_TAG  | {2'b00, cp[17:12]};
         p.bytes[2] = CONT_TAG  | {2'b00, cp[11:6]};
         p.bytes[3] = CONT_TAG  | {2'b00, cp[5:0]};
         p.count    = 3'd4;
      end
      return p;
   endfunction

   localparam point_type REPL_BYTES = encode_point(REPL_CP);

endpackage

FILE: sv/u2u8_req_if.sv
// Code unit channel: valid/ready handshake with one UTF-16 code unit per beat.
interface u2u8_req_if;
   import u2u8_pkg::*;

   logic              valid;
   logic              ready;
   logic [UNIT_W-1:0] code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink   (input valid, input code_unit, output ready);
endinterface

FILE: sv/u2u8_rsp_if.sv
// Byte channel: valid/ready handshake with one UTF-8 byte and a last flag per beat.
interface u2u8_rsp_if;
   import u2u8_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

FILE: sv/u2u8_front.sv
// Front end: accepts code units, tracks the pending high surrogate, builds byte bursts.
module u2u8_front (
   input  logic                clock,
   input  logic                reset,
   u2u8_req_if.sink            req_ch,
   input  logic                full,
   output logic                push,
   output u2u8_pkg::burst_type burst
);
   import u2u8_pkg::*;

   logic              pend_ff, pend_in;
   logic [SURR_W-1:0] hb_ff, hb_in;
   logic              accept;
   logic              is_high, is_low;
   logic              pre_repl, has_point;
   logic [CP_W-1:0]   point_cp, pair_cp;
   point_type         enc;
   logic [UNIT_W-1:0] u;

   assign u       = req_ch.code_unit;
   assign is_high = (u[15:10] == HIGH_TAG);
   assign is_low  = (u[15:10] == LOW_TAG);
   assign pair_cp = SUPP_BASE + {1'b0, hb_ff, u[SURR_W-1:0]};

   assign req_ch.ready = !full;
   assign accept       = req_ch.valid && !full;

   always_comb begin
      pre_repl  = 1'b0;
      has_point = 1'b0;
      point_cp  = '0;
      pend_in   = pend_ff;
      hb_in     = hb_ff;
      if (pend_ff) begin
         if (is_low) begin
            has_point = 1'b1;
            point_cp  = pair_cp;
            pend_in   = 1'b0;
         end else begin
            // unpaired high surrogate turns into U+FFFD ahead of this unit
            pre_repl = 1'b1;
            pend_in  = 1'b0;
            if (is_high) begin
               pend_in = 1'b1;
               hb_in   = u[SURR_W-1:0];
            end else begin
               has_point = 1'b1;
               point_cp  = {5'b00000, u};
            end
         end
      end else begin
         if (is_high) begin
            pend_in = 1'b1;
            hb_in   = u[SURR_W-1:0];
         end else if (is_low) begin
            has_point = 1'b1;
            point_cp  = REPL_CP;
         end else begin
            has_point = 1'b1;
            point_cp  = {5'b00000, u};
         end
      end
   end

   assign enc = encode_point(point_cp);

   // with a leading U+FFFD the second point is always BMP, three bytes at most
   always_comb begin
      burst = '0;
      if (pre_repl) begin
         burst.bytes[2:0] = REPL_BYTES.bytes[2:0];
         burst.bytes[5:3] = enc.bytes[2:0];
         burst.count      = has_point ? CNT_W'(REPL_BYTES.count + enc.count)
                                      : REPL_BYTES.count;
      end else begin
         burst.bytes[3:0] = enc.bytes;
         burst.count      = has_point ? enc.count : '0;
      end
   end

   assign push = accept && (burst.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         hb_ff   <= '0;
      end else if (accept) begin
         pend_ff <= pend_in;
         hb_ff   <= hb_in;
      end
   end

endmodule

FILE: sv/u2u8_queue.sv
// Small register FIFO of byte bursts between the front and back ends.
module u2u8_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  u2u8_pkg::burst_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output u2u8_pkg::burst_type head
);
   import u2u8_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   burst_type         mem_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wr_ff + 1'b1);
      if (do_pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : AW'(rd_ff + 1'b1);
      if (do_push && !do_pop)      cnt_in = CW'(cnt_ff + 1'b1);
      else if (do_pop && !do_push) cnt_in = CW'(cnt_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule

FILE: sv/u2u8_back.sv
// Back end: walks each burst one byte per beat into a registered output stage.
module u2u8_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  u2u8_pkg::burst_type head,
   output logic                pop,
   u2u8_rsp_if.source          rsp_ch
);
   import u2u8_pkg::*;

   burst_type         cur_ff, cur_in, src;
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              oval_ff, oval_in;
   logic [BYTE_W-1:0] obyte_ff, obyte_in;
   logic              olast_ff, olast_in;
   logic              advance, src_valid, is_last;

   // work straight off the queue head when idle, so bursts run without gaps
   assign src       = busy_ff ? cur_ff : head;
   assign src_valid = busy_ff || head_valid;
   assign advance   = !oval_ff || rsp_ch.ready;
   assign is_last   = (idx_ff == IDX_W'(src.count - 1'b1));
   assign pop       = advance && !busy_ff && head_valid;

   always_comb begin
      cur_in   = cur_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      oval_in  = oval_ff && !rsp_ch.ready;
      obyte_in = obyte_ff;
      olast_in = olast_ff;
      if (advance && src_valid) begin
         oval_in  = 1'b1;
         obyte_in = src.bytes[idx_ff];
         olast_in = is_last;
         if (is_last) begin
            busy_in = 1'b0;
            idx_in  = '0;
         end else begin
            busy_in = 1'b1;
            idx_in  = IDX_W'(idx_ff + 1'b1);
            if (!busy_ff) cur_in = head;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         oval_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         oval_ff <= oval_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
   end

   assign rsp_ch.valid    = oval_ff;
   assign rsp_ch.out_byte = obyte_ff;
   assign rsp_ch.last     = olast_ff;

endmodule

FILE: sv/utf16_to_utf8_transcoder.sv
// The first byte of a code unit passes through the queue and then the registered output stage to rsp_ch.
// Throughput: one output byte per cycle while rsp_ch is ready, set by the single-byte output stage;
// a unit yields 0 to 6 bytes (1 to 3 for a BMP character).
// A lone high surrogate yields no bytes and is accepted whenever the queue has room.
// Reset (synchronous, active high) clears the pending surrogate, the queue and the output.
module utf16_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   u2u8_req_if.sink   req_ch,
   u2u8_rsp_if.source rsp_ch
);
   import u2u8_pkg::*;

   logic      push, full, pop, head_valid;
   burst_type burst, head;

   u2u8_front front_u (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .full   (full),
      .push   (push),
      .burst  (burst)
   );

   u2u8_queue #(.DEPTH(QUEUE_DEPTH)) queue_u (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (burst),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   u2u8_back back_u (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

FILE: sv/u2u8_checker.sv
// Port-level checks for the transcoder, bound to the top level.
module u2u8_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       last
);
   logic mid_ff;

   // set while the bytes of one unit are still coming
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         mid_ff <= !last;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_first_is_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !mid_ff |-> out_byte[7:6] != 2'b10)
      else $error("continuation byte opens a unit's output");

   a_ascii_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !out_byte[7] |-> last)
      else $error("single-byte character not flagged last");

   a_no_bad_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> out_byte[7:3] != 5'b11111)
      else $error("invalid UTF-8 byte value");

   logic unused_req;
   assign unused_req = req_valid & req_ready;

endmodule

bind utf16_to_utf8_transcoder u2u8_checker checker_u (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .out_byte  (rsp_ch.out_byte),
   .last      (rsp_ch.last)
);

FILE: tb/utf8_stream_checker.sv
// Checker: predicts the UTF-8 byte stream from accepted code units and compares it beat by beat.
`timescale 1ns / 100ps

module utf8_stream_checker (
   input  logic        clock,
   input  logic        reset,
   u2u8_req_if         req_mon,
   u2u8_rsp_if         rsp_mon,
   input  logic        stream_done,
   output int unsigned error_count,
   output int unsigned bytes_checked,
   output int unsigned bytes_owed
);
   import u2u8_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } utf8_beat_type;

   logic               hs_held;
   logic [SURR_W-1:0]  hs_bits;
   logic [BYTE_W-1:0]  staged[$];
   utf8_beat_type      bytes_due[$];
   logic               drain_checked;

   initial begin
      error_count   = 0;
      bytes_checked = 0;
      bytes_owed    = 0;
      drain_checked = 1'b0;
      hs_held       = 1'b0;
      hs_bits       = '0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      error_count++;
   endtask

   function automatic void stage_code_point(input logic [CP_W-1:0] cp);
      if (cp < LIMIT_1BYTE) begin
         staged.push_back(cp[7:0]);
      end else if (cp < LIMIT_2BYTE) begin
         staged.push_back(LEAD2_TAG | {3'b000, cp[10:6]});
         staged.push_back(CONT_TAG | {2'b00, cp[5:0]});
      end else if (cp < LIMIT_3BYTE) begin
         staged.push_back(LEAD3_TAG | {4'b0000, cp[15:12]});
         staged.push_back(CONT_TAG | {2'b00, cp[11:6]});
         staged.push_back(CONT_TAG | {2'b00, cp[5:0]});
      end else begin
         staged.push_back(LEAD4_TAG | {5'b00000, cp[20:18]});
         staged.push_back(CONT_TAG | {2'b00, cp[17:12]});
         staged.push_back(CONT_TAG | {2'b00, cp[11:6]});
         staged.push_back(CONT_TAG | {2'b00, cp[5:0]});
      end
   endfunction

   function automatic void predict_unit(input logic [UNIT_W-1:0] unit);
      logic          is_high;
      logic          is_low;
      utf8_beat_type beat;
      is_high = (unit[15:10] == HIGH_TAG);
      is_low  = (unit[15:10] == LOW_TAG);
      staged.delete();
      if (hs_held && is_low) begin
         stage_code_point(SUPP_BASE + {1'b0, hs_bits, unit[9:0]});
         hs_held = 1'b0;
         hs_bits = '0;
      end else begin
         // an unpaired high surrogate turns into U+FFFD before the new unit
         if (hs_held) begin
            stage_code_point(REPL_CP);
            hs_held = 1'b0;
            hs_bits = '0;
         end
         if (is_high) begin
            hs_held = 1'b1;
            hs_bits = unit[9:0];
         end else begin
            stage_code_point(is_low ? REPL_CP : {5'b00000, unit});
         end
      end
      for (int i = 0; i < staged.size(); i++) begin
         beat.data = staged[i];
         beat.last = (i == staged.size() - 1);
         bytes_due.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin
      utf8_beat_type want;
      if (reset) begin
         hs_held = 1'b0;
         hs_bits = '0;
         bytes_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_unit(req_mon.code_unit);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected byte 0x%02h last=%0b",
                                         rsp_mon.out_byte, rsp_mon.last));
            end else begin
               want = bytes_due.pop_front();
               bytes_checked++;
               if (rsp_mon.out_byte !== want.data)
                  report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h",
                                            rsp_mon.out_byte, want.data));
               if (rsp_mon.last !== want.last)
                  report_mismatch($sformatf("last %0b on byte 0x%02h, want %0b",
                                            rsp_mon.last, want.data, want.last));
            end
         end
         if (stream_done && !drain_checked) begin
            drain_checked = 1'b1;
            while (bytes_due.size() != 0) begin
               want = bytes_due.pop_front();
               report_mismatch($sformatf("byte 0x%02h last=%0b never arrived",
                                         want.data, want.last));
            end
         end
      end
      bytes_owed = bytes_due.size();
   end

endmodule

FILE: tb/tb_utf16_to_utf8_transcoder.sv
// Testbench top: clock, reset, code unit stimulus, byte-side back-pressure and verdict.
`timescale 1ns / 100ps

module tb_utf16_to_utf8_transcoder;
   import u2u8_pkg::*;

   localparam int RANDOM_UNITS = 330;
   localparam int DRAIN_LIMIT  = 5000;

   localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hD800;
   localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hDC00;

   typedef enum {PICK_ASCII, PICK_TWO, PICK_THREE, PICK_PAIR,
                 PICK_HIGH, PICK_LOW, PICK_ANY} unit_kind_type;

   // length boundaries, surrogate pairs at both ends, and every unpaired case
   localparam logic [UNIT_W-1:0] DIRECTED_UNITS [22] = '{
      16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000,
      16'hFFFD, 16'hFFFF, 16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hDC00,
      16'hD800, 16'hDBFF, 16'h0041, 16'hDA55, 16'h0000, 16'hD801, 16'hFFFF,
      16'hDFFF
   };

   logic        clock;
   logic        reset;
   logic        stream_done;
   logic        pace_on;
   int unsigned error_count;
   int unsigned bytes_checked;
   int unsigned bytes_owed;
   int unsigned units_sent;
   int unsigned pairs_sent;

   u2u8_req_if req_ch ();
   u2u8_rsp_if rsp_ch ();

   utf16_to_utf8_transcoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   utf8_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .stream_done   (stream_done),
      .error_count   (error_count),
      .bytes_checked (bytes_checked),
      .bytes_owed    (bytes_owed)
   );

   initial clock = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("Timeout: byte stream did not drain");
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_unit(input logic [UNIT_W-1:0] unit);
      int gap;
      if (units_sent % 40 == 0)
         pace_on <= ($urandom_range(0, 3) != 0);
      gap = pace_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.code_unit <= unit;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      units_sent++;
   endtask

   function automatic unit_kind_type pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return PICK_ASCII;
      if (roll < 35) return PICK_TWO;
      if (roll < 58) return PICK_THREE;
      if (roll < 80) return PICK_PAIR;
      if (roll < 86) return PICK_HIGH;
      if (roll < 92) return PICK_LOW;
      return PICK_ANY;
   endfunction

   // byte side: a fresh stall draw for every beat
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pace_on ? $urandom_range(0, 7) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   initial begin
      int unsigned random_sent;
      int          guard;
      logic [UNIT_W-1:0] pick;
      reset            <= 1'b1;
      stream_done      <= 1'b0;
      pace_on          <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.code_unit <= '0;
      units_sent = 0;
      pairs_sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_UNITS[i])
         send_unit(DIRECTED_UNITS[i]);
      pairs_sent = 2;

      random_sent = 0;
      while (random_sent < RANDOM_UNITS) begin
         case (pick_kind())
            PICK_ASCII: pick = 16'($urandom_range(16'h0000, 16'h007F));
            PICK_TWO:   pick = 16'($urandom_range(16'h0080, 16'h07FF));
            PICK_THREE: begin
               if ($urandom_range(0, 1))
                  pick = 16'($urandom_range(16'h0800, 16'hD7FF));
               else
                  pick = 16'($urandom_range(16'hE000, 16'hFFFF));
            end
            PICK_PAIR: begin
               send_unit(HIGH_FIRST | 16'($urandom_range(0, 16'h03FF)));
               random_sent++;
               pairs_sent++;
               pick = LOW_FIRST | 16'($urandom_range(0, 16'h03FF));
            end
            PICK_HIGH:  pick = HIGH_FIRST | 16'($urandom_range(0, 16'h03FF));
            PICK_LOW:   pick = LOW_FIRST | 16'($urandom_range(0, 16'h03FF));
            default:    pick = 16'($urandom_range(0, 16'hFFFF));
         endcase
         send_unit(pick);
         random_sent++;
      end
      req_ch.valid <= 1'b0;

      guard = 0;
      while (bytes_owed != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      stream_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Sent %0d code units (%0d surrogate pairs offered), compared %0d UTF-8 bytes.",
               units_sent, pairs_sent, bytes_checked);
      $display("Covered length boundaries, unpaired high/low surrogates and random stalls.");
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
